// ===== sv/fbpa_pkg.sv =====
// ============================================================================
// fbpa_pkg
// Shared types and codes for the fixed block pool allocator.
// ============================================================================
`default_nettype none

package fbpa_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int BYTES_W    = 22;

	// tdata / tuser widths
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 192;
	localparam int M_TUSER_W = 3;

	// request kinds
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_RESET = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ALIGN = 3'd1;
	localparam logic [2:0] ST_SIZE  = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_NULL  = 3'd4;
	localparam logic [2:0] ST_RANGE = 3'd5;

	// register indexes
	localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [1:0] REG_BLOCK_ALIGN = 2'd1;
	localparam logic [1:0] REG_POOL_BLOCKS = 2'd2;
	localparam logic [1:0] REG_BASE_ADDR   = 2'd3;

	// register reset values
	localparam logic [15:0]      RST_BLOCK_SIZE  = 16'd64;
	localparam logic [15:0]      RST_BLOCK_ALIGN = 16'd8;
	localparam logic [CNT_W-1:0] RST_POOL_BLOCKS = 7'd64;
	localparam logic [31:0]      RST_BASE_ADDR   = 32'd0;

	typedef struct packed {
		logic [2:0]         status;
		logic [IDX_W-1:0]   granted_block;
		logic [31:0]        granted_address;
		logic [CNT_W-1:0]   free_blocks;
		logic [BYTES_W-1:0] used_bytes;
		logic [BYTES_W-1:0] spare_bytes;
		logic [31:0]        allocation_total;
		logic [31:0]        failure_total;
		logic [31:0]        release_total;
	} result_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] lim;
		lim = CNT_W'(NUM_BLOCKS);
		return (n > lim) ? lim : n;
	endfunction

endpackage

`default_nettype wire

// ===== sv/fbpa_ram.sv =====
// ============================================================================
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/fixed_block_pool_allocator_unit.sv =====
// ============================================================================
// fixed_block_pool_allocator_unit
// LIFO free-list allocator over a pool of equal-size blocks.
// ============================================================================
// Results are registered: into the output register, or into the skid while the output stalls.
// Throughput: one request per cycle while s_tready is high; the link RAM reads the new head's
//   link in the same cycle that the head moves, so pops and pushes go back to back.
// Output register plus skid take one more request while m_tready is low, then s_tready drops.
// Reset (arst_n low): registers go to their reset values, pool rebuilt from
//   fresh blocks 0..n-1, counters zeroed. Link RAM is not cleared.
`default_nettype none

module fixed_block_pool_allocator_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           wr_en,
	input  wire logic [1:0]                     wr_index,
	input  wire logic [31:0]                    wr_data,
	// request stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [15:0] request_bytes, [31:16] request_alignment, [37:32] free_block,
	// [38] free_is_null, [39] zero
	input  wire logic [fbpa_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] mode
	input  wire logic [fbpa_pkg::S_TUSER_W-1:0] s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [5:0] granted_block, [37:6] granted_address, [44:38] free_blocks,
	// [66:45] used_bytes, [88:67] spare_bytes, [120:89] allocation_total,
	// [152:121] failure_total, [184:153] release_total, [191:185] zero
	output logic [fbpa_pkg::M_TDATA_W-1:0]      m_tdata,
	// [2:0] status
	output logic [fbpa_pkg::M_TUSER_W-1:0]      m_tuser
);

	import fbpa_pkg::*;

	// ---------------- configuration registers ----------------
	logic [15:0]      blk_size_q;
	logic [15:0]      blk_align_q;
	logic [CNT_W-1:0] pool_blocks_q;
	logic [31:0]      base_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_size_q    <= RST_BLOCK_SIZE;
			blk_align_q   <= RST_BLOCK_ALIGN;
			pool_blocks_q <= RST_POOL_BLOCKS;
			base_addr_q   <= RST_BASE_ADDR;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLOCK_SIZE:  blk_size_q    <= wr_data[15:0];
				REG_BLOCK_ALIGN: blk_align_q   <= wr_data[15:0];
				REG_POOL_BLOCKS: pool_blocks_q <= wr_data[CNT_W-1:0];
				REG_BASE_ADDR:   base_addr_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- pool state ----------------
	logic [CNT_W-1:0] pool_cnt_q;   // latched pool size
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] fresh_q;      // next never-used block
	logic [CNT_W-1:0] list_len_q;   // entries on the free list
	logic [IDX_W-1:0] head_q;
	logic             byp_q;        // link of head was written in the same cycle as the read
	logic [IDX_W-1:0] byp_link_q;
	logic [31:0]      alloc_tot_q;
	logic [31:0]      fail_tot_q;
	logic [31:0]      rel_tot_q;

	logic [CNT_W-1:0] pool_cnt_d, free_cnt_d, fresh_d, list_len_d;
	logic [IDX_W-1:0] head_d;
	logic             byp_d;
	logic [IDX_W-1:0] byp_link_d;
	logic [31:0]      alloc_tot_d, fail_tot_d, rel_tot_d;

	// link RAM
	logic             ram_we;
	logic [IDX_W-1:0] ram_rdata;
	logic [IDX_W-1:0] head_link;

	// request fields
	logic [1:0]       req_mode;
	logic [15:0]      req_bytes;
	logic [15:0]      req_align;
	logic [IDX_W-1:0] req_blk;
	logic             req_null;

	assign req_mode  = s_tuser;
	assign req_bytes = s_tdata[15:0];
	assign req_align = s_tdata[31:16];
	assign req_blk   = s_tdata[37:32];
	assign req_null  = s_tdata[38];

	logic in_fire;
	logic out_fire;
	assign in_fire  = s_tvalid & s_tready;
	assign out_fire = m_tvalid & m_tready;

	assign head_link = byp_q ? byp_link_q : ram_rdata;

	// ---------------- request evaluation ----------------
	logic [2:0]         status;
	logic [IDX_W-1:0]   granted;
	logic               alloc_ok;
	logic [21:0]        grant_off;
	logic [CNT_W-1:0]   used_cnt;
	logic [21:0]        used_prod;
	logic [21:0]        free_prod;
	result_t            res;

	always_comb begin
		pool_cnt_d  = pool_cnt_q;
		free_cnt_d  = free_cnt_q;
		fresh_d     = fresh_q;
		list_len_d  = list_len_q;
		head_d      = head_q;
		byp_d       = byp_q;
		byp_link_d  = byp_link_q;
		alloc_tot_d = alloc_tot_q;
		fail_tot_d  = fail_tot_q;
		rel_tot_d   = rel_tot_q;
		ram_we      = 1'b0;
		status      = ST_OK;
		granted     = '0;
		alloc_ok    = 1'b0;

		unique case (req_mode)
			MODE_ALLOC: begin
				// alignment, then size, then empty
				priority if (req_align > blk_align_q) begin
					status = ST_ALIGN;
				end else if (req_bytes > blk_size_q) begin
					status = ST_SIZE;
				end else if (free_cnt_q == '0) begin
					status = ST_EMPTY;
				end else if (list_len_q != '0) begin
					// pop list head
					granted    = head_q;
					head_d     = head_link;
					byp_d      = 1'b0;
					list_len_d = list_len_q - CNT_W'(1);
				end else if (fresh_q < pool_cnt_q) begin
					granted = fresh_q[IDX_W-1:0];
					fresh_d = fresh_q + CNT_W'(1);
				end else begin
					status = ST_EMPTY;
				end
				if (status == ST_OK) begin
					alloc_ok    = 1'b1;
					free_cnt_d  = free_cnt_q - CNT_W'(1);
					alloc_tot_d = alloc_tot_q + 32'd1;
				end else begin
					fail_tot_d = fail_tot_q + 32'd1;
				end
			end
			MODE_FREE: begin
				priority if (req_null) begin
					status = ST_NULL;
				end else if ({1'b0, req_blk} >= pool_cnt_q || free_cnt_q >= pool_cnt_q) begin
					status = ST_RANGE;
				end else begin
					// push: new head links to old head; its RAM read returns stale data, so bypass it
					ram_we     = 1'b1;
					head_d     = req_blk;
					byp_d      = 1'b1;
					byp_link_d = head_q;
					list_len_d = list_len_q + CNT_W'(1);
					free_cnt_d = free_cnt_q + CNT_W'(1);
					rel_tot_d  = rel_tot_q + 32'd1;
				end
			end
			MODE_RESET: begin
				pool_cnt_d = clamp_count(pool_blocks_q);
				free_cnt_d = clamp_count(pool_blocks_q);
				fresh_d    = '0;
				list_len_d = '0;
				head_d     = '0;
				byp_d      = 1'b0;
			end
			MODE_NONE: ;
			default: ;
		endcase

		grant_off = 22'(granted) * 22'(blk_size_q);
		used_cnt  = (pool_cnt_d >= free_cnt_d) ? (pool_cnt_d - free_cnt_d) : '0;
		used_prod = 22'(used_cnt) * 22'(blk_size_q);
		free_prod = 22'(free_cnt_d) * 22'(blk_size_q);

		res.status           = status;
		res.granted_block    = granted;
		res.granted_address  = alloc_ok ? (base_addr_q + {10'd0, grant_off}) : 32'd0;
		res.free_blocks      = free_cnt_d;
		res.used_bytes       = used_prod;
		res.spare_bytes      = free_prod;
		res.allocation_total = alloc_tot_d;
		res.failure_total    = fail_tot_d;
		res.release_total    = rel_tot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cnt_q  <= clamp_count(RST_POOL_BLOCKS);
			free_cnt_q  <= clamp_count(RST_POOL_BLOCKS);
			fresh_q     <= '0;
			list_len_q  <= '0;
			head_q      <= '0;
			byp_q       <= 1'b0;
			byp_link_q  <= '0;
			alloc_tot_q <= '0;
			fail_tot_q  <= '0;
			rel_tot_q   <= '0;
		end else if (in_fire) begin
			pool_cnt_q  <= pool_cnt_d;
			free_cnt_q  <= free_cnt_d;
			fresh_q     <= fresh_d;
			list_len_q  <= list_len_d;
			head_q      <= head_d;
			byp_q       <= byp_d;
			byp_link_q  <= byp_link_d;
			alloc_tot_q <= alloc_tot_d;
			fail_tot_q  <= fail_tot_d;
			rel_tot_q   <= rel_tot_d;
		end
	end

	// read address follows the next head, so ram_rdata is the link of head_q unless byp_q is set
	fbpa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(NUM_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we & in_fire),
		.waddr(req_blk),
		.wdata(head_q),
		.raddr(in_fire ? head_d : head_q),
		.rdata(ram_rdata)
	);

	// ---------------- output register and skid ----------------
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign s_tready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res;
			end
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {7'd0,
		out_q.release_total,
		out_q.failure_total,
		out_q.allocation_total,
		out_q.spare_bytes,
		out_q.used_bytes,
		out_q.free_blocks,
		out_q.granted_address,
		out_q.granted_block};

	// ---------------- assertions ----------------
	a_free_le_pool: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= pool_cnt_q)
		else $error("free count above pool count");

	a_list_le_free: assert property (@(posedge clk) disable iff (!arst_n)
		list_len_q <= free_cnt_q)
		else $error("free list longer than free count");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted request produced no result");

	a_out_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !skid_valid_q && !in_fire |=> !out_valid_q)
		else $error("result delivered twice");

endmodule

`default_nettype wire
